/* src/ptsamp_pkg.sv */
// shared constants, types and functions of the projectile trajectory sampler
package ptsamp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS      = 16;
  localparam int CORDIC_STEPS   = 20;
  localparam int STEP_W         = 5;
  localparam int ANG_W          = 16;
  localparam int REM_W          = 14;
  localparam int CS_W           = 31;
  localparam int DIVN_W         = 32 + FRAC_BITS;
  localparam int DIVD_W         = 32;
  localparam int T_W            = DIVN_W + 6;
  localparam int MRES_W         = 62;

  localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd11520;
  localparam logic [ANG_W-1:0] HALF_TURN    = 16'd23040;
  localparam logic [ANG_W-1:0] THREE_QUART  = 16'd34560;
  localparam logic [ANG_W-1:0] FULL_TURN    = 16'd46080;
  localparam logic [CS_W-1:0]  ONE_Q30      = 31'h4000_0000;
  localparam logic [CS_W-1:0]  CORDIC_K     = 31'd652032874;

  // register indexes of the configuration port
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_SPEED   = 2'd1;
  localparam logic [1:0] REG_ANGLE   = 2'd2;

  localparam logic [23:0] GRAVITY_RST = 24'd642253;
  localparam logic [31:0] SPEED_RST   = 32'd0;
  localparam logic [15:0] ANGLE_RST   = 16'd5760;

  // product shift select
  localparam logic [1:0] SH_F  = 2'd0;
  localparam logic [1:0] SH_F1 = 2'd1;
  localparam logic [1:0] SH_30 = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] shsel;
  } mul_req_t;

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:    atan_lut = 22'd2949120;
      5'd1:    atan_lut = 22'd1740967;
      5'd2:    atan_lut = 22'd919879;
      5'd3:    atan_lut = 22'd466945;
      5'd4:    atan_lut = 22'd234379;
      5'd5:    atan_lut = 22'd117304;
      5'd6:    atan_lut = 22'd58666;
      5'd7:    atan_lut = 22'd29335;
      5'd8:    atan_lut = 22'd14668;
      5'd9:    atan_lut = 22'd7334;
      5'd10:   atan_lut = 22'd3667;
      5'd11:   atan_lut = 22'd1833;
      5'd12:   atan_lut = 22'd917;
      5'd13:   atan_lut = 22'd458;
      5'd14:   atan_lut = 22'd229;
      5'd15:   atan_lut = 22'd115;
      5'd16:   atan_lut = 22'd57;
      5'd17:   atan_lut = 22'd29;
      5'd18:   atan_lut = 22'd14;
      5'd19:   atan_lut = 22'd7;
      default: atan_lut = 22'd0;
    endcase
  endfunction

  // clamp a signed 64-bit value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) sat32 = 32'h7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

/* src/ptsamp_if.sv */
// valid/ready channel interfaces for input items and result points
interface ptsamp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [6:0]  num_points;
  modport source (output valid, distance, num_points, input ready);
  modport sink (input valid, distance, num_points, output ready);
endinterface

interface ptsamp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               last;
  logic               fault;
  modport source (output valid, pos_x, pos_y, last, fault, input ready);
  modport sink (input valid, pos_x, pos_y, last, fault, output ready);
endinterface

/* src/projectile_trajectory_sampler_core.sv */
// Trajectory sampler top: config registers, sequencer and shared units.
// The first point follows the input transfer after the cordic, the two velocity products,
// the two divisions and the four point products; the cordic is skipped on an axis angle.
// Each further point takes four multiplier passes plus the transfer, plus any output stall;
// a zero vx gives its fault result after the velocity products, without the divisions.
// One item at a time, input ready only while idle; synchronous reset loads the defaults.
module projectile_trajectory_sampler_core import ptsamp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ptsamp_in_if.sink    in_ch,
  ptsamp_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CORDIC = 4'd1;
  localparam logic [3:0] S_MVX    = 4'd2;
  localparam logic [3:0] S_MVY    = 4'd3;
  localparam logic [3:0] S_DIV1   = 4'd4;
  localparam logic [3:0] S_DIV2   = 4'd5;
  localparam logic [3:0] S_MX     = 4'd6;
  localparam logic [3:0] S_MA     = 4'd7;
  localparam logic [3:0] S_MSQ    = 4'd8;
  localparam logic [3:0] S_MB     = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [23:0] gravity;
  logic [31:0] launch_speed;
  logic [15:0] launch_angle;

  logic [3:0]  state;
  logic [31:0] distance;
  logic [6:0]  npts, k;
  logic [1:0]  quad;
  logic [CS_W-1:0] sn_mag;
  logic        cs_neg, sn_neg;
  logic [31:0] vx_mag, vy_mag;
  logic [DIVN_W-1:0] step;
  logic [T_W-1:0] t;
  logic [MRES_W-1:0] a_mag;

  logic [ANG_W-1:0] ang_red;
  logic [1:0]       q_in;
  logic [REM_W-1:0] r_in;
  logic [6:0]       n_in;

  mul_req_t          mreq;
  logic [63:0]       ma, mb;
  logic              mdone;
  logic [MRES_W-1:0] mres;

  logic              cstart, cdone;
  logic [CS_W-1:0]   cord_c, cord_s;

  logic              dstart, ddone;
  logic [DIVN_W-1:0] dnum, dquo;
  logic [DIVD_W-1:0] dden;

  logic signed [63:0] a_sgn, y_val;
  logic               wr_en;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity      <= GRAVITY_RST;
      launch_speed <= SPEED_RST;
      launch_angle <= ANGLE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GRAVITY: gravity      <= pwdata[23:0];
        REG_SPEED:   launch_speed <= pwdata;
        REG_ANGLE:   launch_angle <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRAVITY: prdata = {8'd0, gravity};
      REG_SPEED:   prdata = launch_speed;
      REG_ANGLE:   prdata = {16'd0, launch_angle};
      default:     prdata = '0;
    endcase
  end

  // angle reduction and quadrant split
  always_comb begin
    ang_red = (launch_angle >= FULL_TURN) ? launch_angle - FULL_TURN : launch_angle;
    if (ang_red < QUARTER_TURN) begin
      q_in = 2'd0;
      r_in = REM_W'(ang_red);
    end else if (ang_red < HALF_TURN) begin
      q_in = 2'd1;
      r_in = REM_W'(ang_red - QUARTER_TURN);
    end else if (ang_red < THREE_QUART) begin
      q_in = 2'd2;
      r_in = REM_W'(ang_red - HALF_TURN);
    end else begin
      q_in = 2'd3;
      r_in = REM_W'(ang_red - THREE_QUART);
    end
    if (in_ch.num_points < 7'd2) n_in = 7'd2;
    else if (in_ch.num_points > 7'(MAX_POINTS)) n_in = 7'(MAX_POINTS);
    else n_in = in_ch.num_points;
  end

  assign in_ch.ready = (state == S_IDLE);

  // signed vertical term minus gravity term
  assign a_sgn = (sn_neg ^ cs_neg) ? -$signed({2'b00, a_mag}) : $signed({2'b00, a_mag});
  assign y_val = a_sgn - $signed({2'b00, mres});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      mreq         <= '0;
      cstart       <= 1'b0;
      dstart       <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      cstart     <= 1'b0;
      dstart     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            distance <= in_ch.distance;
            npts     <= n_in;
            quad     <= q_in;
            if (r_in == '0) begin
              // exact axis angle
              case (q_in)
                2'd0: begin cs_neg <= 1'b0; sn_mag <= '0; sn_neg <= 1'b0; end
                2'd1: begin cs_neg <= 1'b1; sn_mag <= ONE_Q30; sn_neg <= 1'b0; end
                2'd2: begin cs_neg <= 1'b1; sn_mag <= '0; sn_neg <= 1'b1; end
                default: begin cs_neg <= 1'b0; sn_mag <= ONE_Q30; sn_neg <= 1'b1; end
              endcase
              state <= S_MVX;
            end else begin
              cstart <= 1'b1;
              state  <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (cdone) begin
            case (quad)
              2'd0: begin cs_neg <= 1'b0; sn_mag <= cord_s; sn_neg <= 1'b0; end
              2'd1: begin cs_neg <= 1'b1; sn_mag <= cord_c; sn_neg <= 1'b0; end
              2'd2: begin cs_neg <= 1'b1; sn_mag <= cord_s; sn_neg <= 1'b1; end
              default: begin cs_neg <= 1'b0; sn_mag <= cord_c; sn_neg <= 1'b1; end
            endcase
            state <= S_MVX;
          end
        end
        S_MVX: begin
          // the product is issued on entry, done moves on
          if (!mreq.start && !mdone && ma != {32'd0, launch_speed}) begin
            ma <= {32'd0, launch_speed};
          end
          if (mdone) begin
            vx_mag <= mres[31:0];
            ma <= {32'd0, launch_speed};
            mb <= {33'd0, sn_mag};
            mreq <= '{start: 1'b1, shsel: SH_30};
            state <= S_MVY;
          end
        end
        S_MVY: begin
          if (mdone) begin
            vy_mag <= mres[31:0];
            if (vx_mag == '0) begin
              out_ch.pos_x <= '0;
              out_ch.pos_y <= '0;
              out_ch.last  <= 1'b1;
              out_ch.fault <= 1'b1;
              out_ch.valid <= 1'b1;
              state        <= S_OUT;
            end else begin
              dnum   <= {distance, FRAC_BITS'(0)};
              dden   <= vx_mag;
              dstart <= 1'b1;
              state  <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (ddone) begin
            dnum   <= dquo;
            dden   <= {25'd0, npts - 7'd1};
            dstart <= 1'b1;
            state  <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (ddone) begin
            step <= dquo;
            t    <= '0;
            k    <= '0;
            ma   <= {32'd0, vx_mag};
            mb   <= '0;
            mreq <= '{start: 1'b1, shsel: SH_F};
            state <= S_MX;
          end
        end
        S_MX: begin
          if (mdone) begin
            out_ch.pos_x <= sat32($signed({2'b00, mres}));
            ma   <= {32'd0, vy_mag};
            mb   <= 64'(t);
            mreq <= '{start: 1'b1, shsel: SH_F};
            state <= S_MA;
          end
        end
        S_MA: begin
          if (mdone) begin
            a_mag <= mres;
            ma   <= 64'(t);
            mb   <= 64'(t);
            mreq <= '{start: 1'b1, shsel: SH_F};
            state <= S_MSQ;
          end
        end
        S_MSQ: begin
          if (mdone) begin
            ma   <= {40'd0, gravity};
            mb   <= {2'b00, mres};
            mreq <= '{start: 1'b1, shsel: SH_F1};
            state <= S_MB;
          end
        end
        S_MB: begin
          if (mdone) begin
            out_ch.pos_y <= sat32(y_val);
            out_ch.last  <= (k == npts - 7'd1);
            out_ch.fault <= 1'b0;
            out_ch.valid <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.last) begin
              state <= S_IDLE;
            end else begin
              // next sample time
              k    <= k + 7'd1;
              t    <= t + T_W'(step);
              ma   <= {32'd0, vx_mag};
              mb   <= 64'(t + T_W'(step));
              mreq <= '{start: 1'b1, shsel: SH_F};
              state <= S_MX;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // entering velocity products
      if (state == S_IDLE && in_ch.valid && r_in == '0) begin
        ma   <= {32'd0, launch_speed};
        mb   <= {33'd0, (q_in[0] ? '0 : ONE_Q30)};
        mreq <= '{start: 1'b1, shsel: SH_30};
      end
      if (state == S_CORDIC && cdone) begin
        ma   <= {32'd0, launch_speed};
        mb   <= {33'd0, (quad[0] ? cord_s : cord_c)};
        mreq <= '{start: 1'b1, shsel: SH_30};
      end
    end
  end

  ptsamp_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .rem   (r_in),
    .done  (cdone),
    .cos_q (cord_c),
    .sin_q (cord_s)
  );

  ptsamp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (ma),
    .b    (mb),
    .done (mdone),
    .res  (mres)
  );

  ptsamp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dstart),
    .dividend (dnum),
    .divisor  (dden),
    .done     (ddone),
    .quo      (dquo)
  );

  // a point is never shown while a new item can be taken
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a point is pending");

  // a fault result always closes the run
  a_fault_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.fault |-> out_ch.last)
    else $error("fault result without last");

  // multiplier is only started while the sequencer is working
  a_mul_busy: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> state != S_IDLE && state != S_OUT)
    else $error("multiplier started outside a product step");

endmodule

/* src/ptsamp_cordic.sv */
// iterative cordic rotation giving clamped first-quadrant cos and sin in q1.30
module ptsamp_cordic import ptsamp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REM_W-1:0] rem,
  output logic             done,
  output logic [CS_W-1:0]  cos_q,
  output logic [CS_W-1:0]  sin_q
);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic signed [33:0] x, y, dx, dy;
  logic signed [26:0] z, at;

  // shift toward zero by the step index
  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                               input logic [STEP_W-1:0] i);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    m = m >> i;
    shr_tz = v[33] ? -$signed(m) : $signed(m);
  endfunction

  assign dx = shr_tz(y, step);
  assign dy = shr_tz(x, step);
  assign at = $signed({5'd0, atan_lut(step)});

  // one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= $signed({3'd0, CORDIC_K});
        y    <= '0;
        z    <= $signed({4'd0, rem, 9'd0});
      end else if (busy) begin
        if (!z[26]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // clamp into [0, 1]
  always_comb begin
    if (x[33]) cos_q = '0;
    else if (x > $signed({3'd0, ONE_Q30})) cos_q = ONE_Q30;
    else cos_q = x[CS_W-1:0];
    if (y[33]) sin_q = '0;
    else if (y > $signed({3'd0, ONE_Q30})) sin_q = ONE_Q30;
    else sin_q = y[CS_W-1:0];
  end

endmodule

/* src/ptsamp_mul.sv */
// shared multiplier: 64x64 magnitude product from four 32x32 partial products, shifted and capped
module ptsamp_mul import ptsamp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [MRES_W-1:0] res
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  a_q, b_q;
  logic [1:0]   sh_q;
  logic [63:0]  pp;
  logic [1:0]   pp_off;
  logic [127:0] acc, sh_val;
  logic [31:0]  a_half, b_half;

  assign a_half = cnt[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (sh_q)
      SH_F:    sh_val = acc >> FRAC_BITS;
      SH_F1:   sh_val = acc >> (FRAC_BITS + 1);
      SH_30:   sh_val = acc >> 30;
      default: sh_val = acc;
    endcase
  end

  // partial product, then accumulate, then shift and cap
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        a_q  <= a;
        b_q  <= b;
        sh_q <= req.shsel;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt < 3'd4) begin
          pp     <= a_half * b_half;
          pp_off <= 2'(cnt[1]) + 2'(cnt[0]);
        end
        if (cnt >= 3'd1 && cnt <= 3'd4)
          acc <= acc + ({64'd0, pp} << (7'd32 * pp_off));
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (sh_val[127:MRES_W] != '0 || sh_val[MRES_W-1:0] > {2'b10, 60'd0})
            res <= {2'b10, 60'd0};
          else
            res <= sh_val[MRES_W-1:0];
        end
      end
    end
  end

endmodule

/* src/ptsamp_div.sv */
// restoring divider, one quotient bit per cycle
module ptsamp_div import ptsamp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] rem, dvs;
  logic [DIVD_W:0]   trial;

  assign trial = {rem, quo[DIVN_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        // trial subtract
        if (trial >= {1'b0, dvs}) begin
          rem <= DIVD_W'(trial - {1'b0, dvs});
          quo <= {quo[DIVN_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIVD_W-1:0];
          quo <= {quo[DIVN_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
